// ----- rtl/rcpd_pkg.sv -----
`timescale 1ns / 1ps
package rcpd_pkg;

  localparam int PACKET_BYTES = 15;
  localparam int HOP_SLOTS    = 4;
  localparam int SUM_BYTES    = 14;
  localparam int HOP_REGS     = 4;

  localparam int COUNT_W     = $clog2(PACKET_BYTES + 1);
  localparam int STORE_DEPTH = SUM_BYTES + 1;
  localparam int STORE_W     = $clog2(STORE_DEPTH);
  localparam int HOP_W       = (HOP_SLOTS > 1) ? $clog2(HOP_SLOTS) : 1;
  localparam int HOP_SEL_W   = $clog2(HOP_REGS);
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0]  GOOD_HEADER  = 8'hA5;
  localparam logic [7:0]  EXPERT_CODE  = 8'hFA;
  localparam logic [2:0]  SKIP_LIMIT   = 3'd5;
  localparam logic [31:0] SKIP_MIN_GAP = 32'd500;
  localparam logic [31:0] SKIP_OFFSET  = 32'd250;
  localparam logic [31:0] SKIP_PERIOD  = 32'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOP_CHANNEL_0 = 3'd0,
    REG_HOP_CHANNEL_1 = 3'd1,
    REG_HOP_CHANNEL_2 = 3'd2,
    REG_HOP_CHANNEL_3 = 3'd3,
    REG_TIMING_HOLD   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        good;
    logic [9:0]  roll;
    logic [9:0]  pitch;
    logic [9:0]  yaw;
    logic [9:0]  throttle;
    logic [5:0]  trim_pitch;
    logic [5:0]  trim_roll;
    logic [5:0]  trim_throttle;
    logic [5:0]  trim_yaw;
    logic [4:0]  flags;
    logic [31:0] ptime;
    logic [31:0] delta;
  } pkt_t;

  // (delta - offset) / period >= k + 1  <=>  delta >= offset + period * (k + 1)
  function automatic logic [31:0] skip_threshold(input logic [2:0] k);
    logic [31:0] thr;
    unique case (k)
      3'd0:    thr = SKIP_OFFSET + SKIP_PERIOD * 1;
      3'd1:    thr = SKIP_OFFSET + SKIP_PERIOD * 2;
      3'd2:    thr = SKIP_OFFSET + SKIP_PERIOD * 3;
      3'd3:    thr = SKIP_OFFSET + SKIP_PERIOD * 4;
      3'd4:    thr = SKIP_OFFSET + SKIP_PERIOD * 5;
      default: thr = '1;
    endcase
    return thr;
  endfunction

endpackage

// ----- rtl/rcpd_if.sv -----
`timescale 1ns / 1ps
interface rcpd_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        first_of_packet;
  logic [31:0] arrival_time;

  modport source(output valid, output rx_byte, output first_of_packet,
                 output arrival_time, input ready);
  modport sink(input valid, input rx_byte, input first_of_packet,
               input arrival_time, output ready);
endinterface

interface rcpd_res_if;
  logic       valid;
  logic       ready;
  logic       packet_good;
  logic [9:0] roll;
  logic [9:0] pitch;
  logic [9:0] yaw;
  logic [9:0] throttle;
  logic [5:0] trim_pitch;
  logic [5:0] trim_roll;
  logic [5:0] trim_throttle;
  logic [5:0] trim_yaw;
  logic [4:0] switch_flags;
  logic [7:0] tune_channel;

  modport source(output valid, output packet_good, output roll, output pitch,
                 output yaw, output throttle, output trim_pitch, output trim_roll,
                 output trim_throttle, output trim_yaw, output switch_flags,
                 output tune_channel, input ready);
  modport sink(input valid, input packet_good, input roll, input pitch,
               input yaw, input throttle, input trim_pitch, input trim_roll,
               input trim_throttle, input trim_yaw, input switch_flags,
               input tune_channel, output ready);
endinterface

// ----- rtl/rcpd_assemble.sv -----
`timescale 1ns / 1ps
module rcpd_assemble
  import rcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        first_of_packet,
  input  logic [31:0] arrival_time,
  input  logic [31:0] last_good_time,
  input  logic        pkt_take,
  output logic        pkt_valid,
  output pkt_t        pkt
);

  logic [7:0]         store [STORE_DEPTH];
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;
  logic [31:0]        packet_time;

  logic [COUNT_W-1:0] cnt;
  logic [7:0]         sum;
  logic [31:0]        ptime;
  logic               live;
  logic               done;
  logic [7:0]         chk;
  pkt_t               pkt_next;

  always_comb begin
    cnt   = first_of_packet ? '0 : byte_count;
    sum   = first_of_packet ? '0 : running_sum;
    ptime = first_of_packet ? arrival_time : packet_time;
    live  = cnt < COUNT_W'(PACKET_BYTES);
    done  = accept && live && (cnt == COUNT_W'(PACKET_BYTES - 1));
    chk   = (cnt == COUNT_W'(SUM_BYTES)) ? rx_byte : store[SUM_BYTES];

    pkt_next.good          = (sum == chk) && (store[0] == GOOD_HEADER);
    pkt_next.roll          = {store[4][1:0], store[5]};
    pkt_next.pitch         = {store[6][1:0], store[7]};
    pkt_next.yaw           = {store[10][1:0], store[11]};
    pkt_next.throttle      = {store[8][1:0], store[9]};
    pkt_next.trim_pitch    = store[6][7:2];
    pkt_next.trim_roll     = store[4][7:2];
    pkt_next.trim_throttle = store[8][7:2];
    pkt_next.trim_yaw      = store[10][7:2];
    pkt_next.flags         = {store[3][7], store[2][3], store[1] == EXPERT_CODE,
                              store[2][1], store[2][0]};
    pkt_next.ptime         = ptime;
    pkt_next.delta         = ptime - last_good_time;
  end

  always_ff @(posedge clk) begin
    if (accept && live && (cnt <= COUNT_W'(SUM_BYTES))) begin
      store[cnt[STORE_W-1:0]] <= rx_byte;
    end
    if (done) begin
      pkt <= pkt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      packet_time <= '0;
      pkt_valid   <= 1'b0;
    end else begin
      if (accept) begin
        packet_time <= ptime;
        if (live) begin
          byte_count  <= cnt + 1'b1;
          running_sum <= (cnt < COUNT_W'(SUM_BYTES)) ? sum + rx_byte : sum;
        end
      end
      if (done) begin
        pkt_valid <= 1'b1;
      end else if (pkt_take) begin
        pkt_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/rc_packet_decoder_hopper.sv -----
`timescale 1ns / 1ps
// After its last byte, a result goes through pkt/pkt_valid, then the result registers.
// Throughput: one byte per cycle while rx.ready is high; one result per packet of PACKET_BYTES bytes.
// Input ready drops only while a finished packet waits behind an unread result.
// Reset (rst, synchronous, active high) clears the byte count, sum, times, hop
// slot, skip count, held trims and flags, and the configuration registers.
module rc_packet_decoder_hopper
  import rcpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  rcpd_rx_if.sink              rx,
  rcpd_res_if.source           result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]       hop_channel [HOP_REGS];
  logic             timing_hold;
  logic [HOP_W-1:0] hop_index;
  logic [31:0]      last_good_time;
  logic [2:0]       skip_count;
  logic [5:0]       held_trim_pitch;
  logic [5:0]       held_trim_roll;
  logic [5:0]       held_trim_throttle;
  logic [5:0]       held_trim_yaw;
  logic [4:0]       held_flags;

  logic             accept;
  logic             pkt_valid;
  pkt_t             pkt;
  logic             pkt_take;
  logic [31:0]      last_good_now;
  logic [HOP_W-1:0] hop_one;
  logic [HOP_W-1:0] hop_two;
  logic [HOP_W-1:0] hop_final;
  logic             take_skip;

  assign pkt_take = pkt_valid && (!result.valid || result.ready);
  assign rx.ready = !(pkt_valid && result.valid && !result.ready);
  assign accept   = rx.valid && rx.ready;

  // a good packet leaving this cycle already counts for the packet closing now
  assign last_good_now = (pkt_take && pkt.good) ? pkt.ptime : last_good_time;

  rcpd_assemble u_assemble (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .rx_byte         (rx.rx_byte),
    .first_of_packet (rx.first_of_packet),
    .arrival_time    (rx.arrival_time),
    .last_good_time  (last_good_now),
    .pkt_take        (pkt_take),
    .pkt_valid       (pkt_valid),
    .pkt             (pkt)
  );

  always_comb begin
    hop_one   = (hop_index == HOP_W'(HOP_SLOTS - 1)) ? '0 : hop_index + 1'b1;
    hop_two   = (hop_one == HOP_W'(HOP_SLOTS - 1)) ? '0 : hop_one + 1'b1;
    take_skip = !pkt.good && !timing_hold && (skip_count < SKIP_LIMIT) &&
                (pkt.delta > SKIP_MIN_GAP) && (pkt.delta >= skip_threshold(skip_count));
    hop_final = take_skip ? hop_two : hop_one;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HOP_REGS; i++) begin
        hop_channel[i] <= '0;
      end
      timing_hold <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_HOP_CHANNEL_0: hop_channel[0] <= cfg_data;
        REG_HOP_CHANNEL_1: hop_channel[1] <= cfg_data;
        REG_HOP_CHANNEL_2: hop_channel[2] <= cfg_data;
        REG_HOP_CHANNEL_3: hop_channel[3] <= cfg_data;
        REG_TIMING_HOLD:   timing_hold    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_index          <= '0;
      last_good_time     <= '0;
      skip_count         <= '0;
      held_trim_pitch    <= '0;
      held_trim_roll     <= '0;
      held_trim_throttle <= '0;
      held_trim_yaw      <= '0;
      held_flags         <= '0;
      result.valid       <= 1'b0;
    end else begin
      if (pkt_take) begin
        hop_index    <= hop_final;
        result.valid <= 1'b1;
        if (pkt.good) begin
          last_good_time     <= pkt.ptime;
          skip_count         <= '0;
          held_trim_pitch    <= pkt.trim_pitch;
          held_trim_roll     <= pkt.trim_roll;
          held_trim_throttle <= pkt.trim_throttle;
          held_trim_yaw      <= pkt.trim_yaw;
          held_flags         <= pkt.flags;
        end else if (take_skip) begin
          skip_count <= skip_count + 1'b1;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      result.packet_good   <= pkt.good;
      result.roll          <= pkt.good ? pkt.roll : '0;
      result.pitch         <= pkt.good ? pkt.pitch : '0;
      result.yaw           <= pkt.good ? pkt.yaw : '0;
      result.throttle      <= pkt.good ? pkt.throttle : '0;
      result.trim_pitch    <= pkt.good ? pkt.trim_pitch : held_trim_pitch;
      result.trim_roll     <= pkt.good ? pkt.trim_roll : held_trim_roll;
      result.trim_throttle <= pkt.good ? pkt.trim_throttle : held_trim_throttle;
      result.trim_yaw      <= pkt.good ? pkt.trim_yaw : held_trim_yaw;
      result.switch_flags  <= pkt.good ? pkt.flags : held_flags;
      result.tune_channel  <= hop_channel[HOP_SEL_W'(hop_final)];
    end
  end

endmodule

// ----- rtl/rcpd_checker.sv -----
`timescale 1ns / 1ps
module rcpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_packet_good,
  input logic [9:0] res_roll,
  input logic [9:0] res_pitch,
  input logic [9:0] res_yaw,
  input logic [9:0] res_throttle
);

  // held result stays until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before taken");

  // sticks are zero on a bad packet
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_packet_good |->
      res_roll == 10'd0 && res_pitch == 10'd0 && res_yaw == 10'd0 &&
      res_throttle == 10'd0)
    else $error("nonzero stick on bad packet");

  // input stalls only behind an unread result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid && !res_ready)
    else $error("input stalled without output backpressure");

  // a fresh result traces back to an accepted input beat
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    !$past(rst, 2) && !$past(rst) && $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
    else $error("result without a completing beat");

endmodule

bind rc_packet_decoder_hopper rcpd_checker u_rcpd_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_valid        (rx.valid),
  .rx_ready        (rx.ready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_packet_good (result.packet_good),
  .res_roll        (result.roll),
  .res_pitch       (result.pitch),
  .res_yaw         (result.yaw),
  .res_throttle    (result.throttle)
);

// ----- verif/rcpd_frame_scoreboard.sv -----
`timescale 1ns / 1ps
module rcpd_frame_scoreboard
  import rcpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  rcpd_rx_if                   rx,
  rcpd_res_if                  result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int unsigned          mismatch_count,
  output int unsigned          pending_frames
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic       good;
    logic [9:0] roll;
    logic [9:0] pitch;
    logic [9:0] yaw;
    logic [9:0] throttle;
    logic [5:0] trim_pitch;
    logic [5:0] trim_roll;
    logic [5:0] trim_throttle;
    logic [5:0] trim_yaw;
    logic [4:0] flags;
    logic [7:0] tune;
  } decoded_t;

  decoded_t expected_frames[$];

  logic [7:0]  hop_ch [HOP_REGS];
  logic        timing_hold;
  logic [7:0]  frame_bytes [PACKET_BYTES];
  int          byte_count;
  logic [7:0]  running_sum;
  logic [31:0] frame_time;
  int          hop_slot;
  logic [31:0] last_good;
  logic [2:0]  skips;
  logic [5:0]  held_trim_pitch;
  logic [5:0]  held_trim_roll;
  logic [5:0]  held_trim_throttle;
  logic [5:0]  held_trim_yaw;
  logic [4:0]  held_flags;
  int unsigned results_seen;

  initial begin
    mismatch_count = 0;
    pending_frames = 0;
    results_seen = 0;
  end

  // Advances the receiver state by one byte; returns 1 when a packet closes.
  function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                     input logic [31:0] t, output decoded_t res);
    logic        good;
    logic [31:0] delta;
    res = '0;
    if (first) begin
      byte_count = 0;
      running_sum = '0;
      frame_time = t;
    end
    if (byte_count >= PACKET_BYTES) return 1'b0;
    frame_bytes[byte_count] = b;
    if (byte_count < SUM_BYTES) running_sum += b;
    byte_count++;
    if (byte_count < PACKET_BYTES) return 1'b0;

    good = (running_sum == frame_bytes[SUM_BYTES]) && (frame_bytes[0] == GOOD_HEADER);
    res.good = good;
    if (good) begin
      res.roll     = {frame_bytes[4][1:0], frame_bytes[5]};
      res.pitch    = {frame_bytes[6][1:0], frame_bytes[7]};
      res.yaw      = {frame_bytes[10][1:0], frame_bytes[11]};
      res.throttle = {frame_bytes[8][1:0], frame_bytes[9]};
      held_trim_pitch    = frame_bytes[6][7:2];
      held_trim_roll     = frame_bytes[4][7:2];
      held_trim_throttle = frame_bytes[8][7:2];
      held_trim_yaw      = frame_bytes[10][7:2];
      held_flags = {frame_bytes[3][7], frame_bytes[2][3], frame_bytes[1] == EXPERT_CODE,
                    frame_bytes[2][1], frame_bytes[2][0]};
      last_good = frame_time;
      skips = '0;
    end

    hop_slot = (hop_slot + 1) % HOP_SLOTS;
    if (skips < SKIP_LIMIT) begin
      delta = frame_time - last_good;
      if (!timing_hold && delta > SKIP_MIN_GAP &&
          (delta - SKIP_OFFSET) / SKIP_PERIOD >= 32'(skips) + 32'd1) begin
        hop_slot = (hop_slot + 1) % HOP_SLOTS;
        skips++;
      end
    end

    res.trim_pitch    = held_trim_pitch;
    res.trim_roll     = held_trim_roll;
    res.trim_throttle = held_trim_throttle;
    res.trim_yaw      = held_trim_yaw;
    res.flags         = held_flags;
    res.tune          = hop_ch[hop_slot];
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t result %0d %s: expected %0d got %0d",
                 $time, results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    decoded_t want;
    decoded_t fresh;
    if (rst) begin
      expected_frames.delete();
      foreach (hop_ch[i]) hop_ch[i] = '0;
      timing_hold = 1'b0;
      byte_count = 0;
      running_sum = '0;
      frame_time = '0;
      hop_slot = 0;
      last_good = '0;
      skips = '0;
      held_trim_pitch = '0;
      held_trim_roll = '0;
      held_trim_throttle = '0;
      held_trim_yaw = '0;
      held_flags = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOP_CHANNEL_0: hop_ch[0] = cfg_data;
          REG_HOP_CHANNEL_1: hop_ch[1] = cfg_data;
          REG_HOP_CHANNEL_2: hop_ch[2] = cfg_data;
          REG_HOP_CHANNEL_3: hop_ch[3] = cfg_data;
          REG_TIMING_HOLD:   timing_hold = cfg_data[0];
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t result %0d arrived with nothing expected", $time, results_seen);
        end else begin
          want = expected_frames.pop_front();
          check_field("packet_good", 10'(want.good), 10'(result.packet_good));
          check_field("roll", want.roll, result.roll);
          check_field("pitch", want.pitch, result.pitch);
          check_field("yaw", want.yaw, result.yaw);
          check_field("throttle", want.throttle, result.throttle);
          check_field("trim_pitch", 10'(want.trim_pitch), 10'(result.trim_pitch));
          check_field("trim_roll", 10'(want.trim_roll), 10'(result.trim_roll));
          check_field("trim_throttle", 10'(want.trim_throttle), 10'(result.trim_throttle));
          check_field("trim_yaw", 10'(want.trim_yaw), 10'(result.trim_yaw));
          check_field("switch_flags", 10'(want.flags), 10'(result.switch_flags));
          check_field("tune_channel", 10'(want.tune), 10'(result.tune_channel));
        end
      end

      if (rx.valid && rx.ready) begin
        if (decode_byte(rx.rx_byte, rx.first_of_packet, rx.arrival_time, fresh))
          expected_frames.push_back(fresh);
      end
    end
    pending_frames <= expected_frames.size();
  end

endmodule

// ----- verif/tb_rc_packet_decoder_hopper.sv -----
`timescale 1ns / 1ps
module tb_rc_packet_decoder_hopper;
  import rcpd_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned PHASE_FRAMES    = 16;

  typedef logic [PACKET_BYTES-1:0][7:0] frame_t;
  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_HEADER, FR_NOISE} frame_kind_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;
  int unsigned mismatch_count;
  int unsigned pending_frames;

  logic calm;
  logic hold_off_req;
  logic hold_off_done;
  logic [31:0] now_us;

  rcpd_rx_if  rx_ch ();
  rcpd_res_if res_ch ();

  rc_packet_decoder_hopper DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcpd_frame_scoreboard scoreboard (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx_ch),
    .result         (res_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_frames (pending_frames)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic frame_t seal_frame(frame_t f, logic corrupt);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < SUM_BYTES; i++) s += f[i];
    f[SUM_BYTES] = corrupt ? s + 8'($urandom_range(1, 255)) : s;
    return f;
  endfunction

  function automatic frame_t build_frame(frame_kind_e kind);
    frame_t f;
    for (int i = 0; i < PACKET_BYTES; i++) f[i] = 8'($urandom());
    if ($urandom_range(3) == 0) f[1] = EXPERT_CODE;
    if (kind == FR_NOISE) return f;
    if (kind == FR_BAD_HEADER) begin
      while (f[0] == GOOD_HEADER) f[0] = 8'($urandom());
    end else begin
      f[0] = GOOD_HEADER;
    end
    return seal_frame(f, kind == FR_BAD_SUM);
  endfunction

  task automatic put_beat(logic [7:0] b, logic first, logic [31:0] t);
    if (!calm && $urandom_range(99) < 14) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid           <= 1'b1;
    rx_ch.rx_byte         <= b;
    rx_ch.first_of_packet <= first;
    rx_ch.arrival_time    <= t;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  // arrival_time after byte 0 is random; the block must ignore it on unmarked bytes
  task automatic send_frame(frame_t f, logic marked, logic [31:0] t);
    for (int i = 0; i < PACKET_BYTES; i++)
      put_beat(f[i], marked && (i == 0), (i == 0) ? t : $urandom());
  endtask

  task automatic send_partial(int unsigned n);
    for (int i = 0; i < n; i++) put_beat(8'($urandom()), i == 0, now_us);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic load_setup(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                            logic [7:0] c3, logic hold);
    write_reg(REG_HOP_CHANNEL_0, c0);
    write_reg(REG_HOP_CHANNEL_1, c1);
    write_reg(REG_HOP_CHANNEL_2, c2);
    write_reg(REG_HOP_CHANNEL_3, c3);
    write_reg(REG_TIMING_HOLD, {7'd0, hold});
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned frames);
    int unsigned sent;
    int unsigned r;
    int unsigned burst;
    frame_kind_e kind;
    sent = 0;
    while (sent < frames) begin
      // lost-link bursts: bad packets spaced to walk the skip counter up
      burst = ($urandom_range(99) < 12) ? $urandom_range(4, 8) : 1;
      repeat (burst) begin
        if (burst > 1) begin
          now_us += $urandom_range(2800, 4200);
          kind = $urandom_range(1) ? FR_BAD_SUM : FR_BAD_HEADER;
        end else begin
          r = $urandom_range(99);
          if (r < 60) now_us += $urandom_range(4000);
          else if (r < 90) now_us += $urandom_range(3000, 20000);
          else if (r < 96) now_us += $urandom();
          else now_us = $urandom();
          r = $urandom_range(99);
          kind = (r < 50) ? FR_GOOD : (r < 70) ? FR_BAD_SUM :
                 (r < 85) ? FR_BAD_HEADER : FR_NOISE;
        end
        if ($urandom_range(24) == 0) send_partial($urandom_range(1, PACKET_BYTES - 1));
        send_frame(build_frame(kind), 1'b1, now_us);
        if ($urandom_range(24) == 0)
          repeat ($urandom_range(1, 3)) put_beat(8'($urandom()), 1'b0, $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    hold_off_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done <= 1'b1;
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    frame_t f;
    rst                   <= 1'b1;
    rx_ch.valid           <= 1'b0;
    rx_ch.rx_byte         <= '0;
    rx_ch.first_of_packet <= 1'b0;
    rx_ch.arrival_time    <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_HOP_CHANNEL_0;
    cfg_data              <= '0;
    calm                  <= 1'b0;
    hold_off_req          <= 1'b0;
    now_us = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_setup(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b0);
    // no mark after reset: packet fills from byte 0 with time 0
    send_frame(build_frame(FR_GOOD), 1'b0, $urandom());
    // restart mid-packet, then an all-ones good packet and stray trailing bytes
    send_partial(5);
    f = '1;
    f[0] = GOOD_HEADER;
    f[1] = EXPERT_CODE;
    send_frame(seal_frame(f, 1'b0), 1'b1, 32'hFFFF_FFFF);
    put_beat(8'hFF, 1'b0, $urandom());
    put_beat(8'h00, 1'b0, $urandom());
    f = '0;
    f[0] = GOOD_HEADER;
    now_us = '0;
    send_frame(seal_frame(f, 1'b0), 1'b1, now_us);
    now_us = 32'd3300;
    send_frame(build_frame(FR_BAD_HEADER), 1'b1, now_us);
    now_us = 32'h8000_0000;
    send_frame(build_frame(FR_BAD_SUM), 1'b1, now_us);
    random_traffic(4);
    settle();

    load_setup(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    random_traffic(PHASE_FRAMES);
    settle();

    hold_off_req <= 1'b1;
    load_setup(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    random_traffic(PHASE_FRAMES);
    settle();

    calm <= 1'b1;
    load_setup(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1);
    random_traffic(PHASE_FRAMES);
    settle();

    calm <= 1'b0;
    load_setup(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b0);
    random_traffic(PHASE_FRAMES);
    settle();

    if (mismatch_count == 0 && pending_frames == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
